>>> sv/hbp_pkg.sv
// Package for the hybrid branch predictor: widths, counter values and training helper.
`default_nettype none
package hbp_pkg;

  localparam int CHOOSER_INDEX_BITS = 10;
  localparam int GSHARE_INDEX_BITS  = 12;
  localparam int HISTORY_BITS       = 8;
  localparam int BIMODAL_INDEX_BITS = 12;

  localparam int ADDR_W = 24;
  // Word address: branch address with the byte offset dropped.
  localparam int WORD_W = ADDR_W - 2;

  localparam int CHOOSER_DEPTH = 1 << CHOOSER_INDEX_BITS;
  localparam int GSHARE_DEPTH  = 1 << GSHARE_INDEX_BITS;
  localparam int BIMODAL_DEPTH = 1 << BIMODAL_INDEX_BITS;

  // Clear counter spans the deepest table.
  localparam int CLR_GB = (GSHARE_INDEX_BITS > BIMODAL_INDEX_BITS) ?
                          GSHARE_INDEX_BITS : BIMODAL_INDEX_BITS;
  localparam int CLR_W  = (CLR_GB > CHOOSER_INDEX_BITS) ? CLR_GB : CHOOSER_INDEX_BITS;

  typedef logic [2:0] ctr_t;
  typedef logic [1:0] sel_t;

  localparam ctr_t CTR_INIT   = 3'd4;
  localparam ctr_t CTR_MAX    = 3'd7;
  localparam ctr_t CTR_MIN    = 3'd0;
  localparam ctr_t CTR_TAKEN  = 3'd4;
  localparam sel_t SEL_INIT   = 2'd1;
  localparam sel_t SEL_MAX    = 2'd3;
  localparam sel_t SEL_MIN    = 2'd0;
  localparam sel_t SEL_GSHARE = 2'd2;

  // Saturating 3-bit counter step towards the outcome.
  function automatic ctr_t train3(input ctr_t c, input logic t);
    ctr_t r;
    if (t) begin
      r = (c < CTR_MAX) ? c + 3'd1 : CTR_MAX;
    end else begin
      r = (c > CTR_MIN) ? c - 3'd1 : CTR_MIN;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/hybrid_branch_predictor.sv
// Top level of the tournament (gshare / bimodal) branch predictor.
`default_nettype none
// Tournament branch predictor. Each input beat carries a branch address and
// its real outcome; each output beat reports the final prediction made
// before training, whether it missed, and which predictor the chooser
// picked. The bimodal, gshare and chooser tables each live in a single-port
// synchronous memory. Accepting a beat issues the table reads and moves to
// lookup; the write-back then trains the chosen counter, the chooser and the
// global history and loads the result register. A new beat is not taken
// until that write-back is done. A result that is not yet taken does not
// hold up the next accept; only the write-back waits for the result
// register to free. After reset a clearing pass writes the reset values
// into every table entry; in_ready stays low throughout.
module hybrid_branch_predictor
  import hbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ADDR_W-1:0] in_branch_address,
  input  wire logic              in_taken,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_predicted_taken,
  output logic                   out_mispredicted,
  output logic                   out_chose_gshare
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;

  // Bookkeeping of the branch under lookup.
  logic [BIMODAL_INDEX_BITS-1:0] bi_r;
  logic [GSHARE_INDEX_BITS-1:0]  gi_r;
  logic [CHOOSER_INDEX_BITS-1:0] ci_r;
  logic                          taken_r;
  logic [HISTORY_BITS-1:0]       ghist_r, ghist_nxt;

  // Result register.
  logic out_valid_r;
  logic out_pred_r, out_miss_r, out_gsh_r;

  // Table memories and their registered read data.
  ctr_t bim_mem [BIMODAL_DEPTH];
  ctr_t gsh_mem [GSHARE_DEPTH];
  sel_t cho_mem [CHOOSER_DEPTH];
  ctr_t bim_rd_r, gsh_rd_r;
  sel_t cho_rd_r;

  logic accept, clearing, lk_done;
  logic [WORD_W-1:0] word, gx;
  logic [BIMODAL_INDEX_BITS-1:0] bi_in;
  logic [GSHARE_INDEX_BITS-1:0]  gi_in;
  logic [CHOOSER_INDEX_BITS-1:0] ci_in;

  logic pb, pg, use_g, pred;
  sel_t sel_nxt;

  logic                          bim_we, gsh_we, cho_we;
  logic [BIMODAL_INDEX_BITS-1:0] bim_wa;
  logic [GSHARE_INDEX_BITS-1:0]  gsh_wa;
  logic [CHOOSER_INDEX_BITS-1:0] cho_wa;
  ctr_t                          bim_wd, gsh_wd;
  sel_t                          cho_wd;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign clearing = (state_r == S_CLEAR);
  // Write-back only once the result register can take the beat.
  assign lk_done  = (state_r == S_LOOKUP) && (!out_valid_r || out_ready);

  // Index generation from the incoming address and current history.
  assign word  = in_branch_address[ADDR_W-1:2];
  assign gx    = word ^ WORD_W'(ghist_r);
  assign bi_in = word[BIMODAL_INDEX_BITS-1:0];
  assign gi_in = gx[GSHARE_INDEX_BITS-1:0];
  assign ci_in = word[CHOOSER_INDEX_BITS-1:0];

  // Prediction and training from the read data.
  always_comb begin
    pb    = (bim_rd_r >= CTR_TAKEN);
    pg    = (gsh_rd_r >= CTR_TAKEN);
    use_g = (cho_rd_r >= SEL_GSHARE);
    pred  = use_g ? pg : pb;
    sel_nxt = cho_rd_r;
    if ((pg == taken_r) && (pb != taken_r)) begin
      if (cho_rd_r < SEL_MAX) sel_nxt = cho_rd_r + 2'd1;
    end else if ((pg != taken_r) && (pb == taken_r)) begin
      if (cho_rd_r > SEL_MIN) sel_nxt = cho_rd_r - 2'd1;
    end
  end

  // Write ports: clearing pass, else write-back of the trained entries.
  always_comb begin
    bim_we = clearing || (lk_done && !use_g);
    gsh_we = clearing || (lk_done && use_g);
    cho_we = clearing || lk_done;
    bim_wa = clearing ? clr_r[BIMODAL_INDEX_BITS-1:0] : bi_r;
    gsh_wa = clearing ? clr_r[GSHARE_INDEX_BITS-1:0]  : gi_r;
    cho_wa = clearing ? clr_r[CHOOSER_INDEX_BITS-1:0] : ci_r;
    bim_wd = clearing ? CTR_INIT : train3(bim_rd_r, taken_r);
    gsh_wd = clearing ? CTR_INIT : train3(gsh_rd_r, taken_r);
    cho_wd = clearing ? SEL_INIT : sel_nxt;
  end

  // Memories: reads are issued only on accept, so read data holds through lookup.
  always_ff @(posedge clk) begin
    if (bim_we) bim_mem[bim_wa] <= bim_wd;
    if (accept) bim_rd_r <= bim_mem[bi_in];
  end

  always_ff @(posedge clk) begin
    if (gsh_we) gsh_mem[gsh_wa] <= gsh_wd;
    if (accept) gsh_rd_r <= gsh_mem[gi_in];
  end

  always_ff @(posedge clk) begin
    if (cho_we) cho_mem[cho_wa] <= cho_wd;
    if (accept) cho_rd_r <= cho_mem[ci_in];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    ghist_nxt = ghist_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {CLR_W{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (lk_done) begin
          state_nxt = S_IDLE;
          // Outcome enters at the top, older bits move down.
          ghist_nxt = (ghist_r >> 1) | (HISTORY_BITS'(taken_r) << (HISTORY_BITS - 1));
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ghist_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ghist_r <= ghist_nxt;
      if (lk_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      bi_r    <= bi_in;
      gi_r    <= gi_in;
      ci_r    <= ci_in;
      taken_r <= in_taken;
    end
    if (lk_done) begin
      out_pred_r <= pred;
      out_miss_r <= pred ^ taken_r;
      out_gsh_r  <= use_g;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_pred_r;
  assign out_mispredicted    = out_miss_r;
  assign out_chose_gshare    = out_gsh_r;

  // An accepted beat always moves into lookup.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOOKUP))
    else $error("accepted beat did not enter lookup");

  // Write-back always presents a result on the next cycle.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    lk_done |=> out_valid_r)
    else $error("write-back without result");

  // History takes the trained outcome at its top bit.
  a_hist_top: assert property (@(posedge clk) disable iff (!rst_n)
    lk_done |=> (ghist_r[HISTORY_BITS-1] == $past(taken_r)))
    else $error("history top bit does not match outcome");

  // No beat is taken during the clearing pass.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("input ready during clearing pass");

endmodule
`default_nettype wire
